>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define EED_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("eed assertion failed");

// Property checked on every clock edge, reset included.
`define EED_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("eed assertion failed");

`endif

>>> hw/rtl/eed_pkg.sv
// ---------------------------------------------------------------------------
// eed_pkg
// Shared types and constants of the echo escape decoder.
// ---------------------------------------------------------------------------
package eed_pkg;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_SEP  = 2'd1,
    OP_END  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_BSLASH  = 3'd1,
    MODE_OCTAL   = 3'd2,
    MODE_HEX     = 3'd3,
    MODE_STOPPED = 3'd4
  } mode_t;

  localparam logic REG_INTERP   = 1'b0;
  localparam logic REG_SUPPRESS = 1'b1;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_ESC    = 8'h1B;

  localparam logic [1:0] OCT_DIGITS = 2'd3;
  localparam logic [1:0] HEX_DIGITS = 2'd2;

  // one queue entry: the one or two output words caused by one input word
  typedef struct packed {
    logic       two;
    logic [7:0] b0;
    logic       v0;
    logic [7:0] b1;
    logic       eoc;
  } entry_t;

endpackage

>>> hw/rtl/echo_escape_decoder.sv
// ---------------------------------------------------------------------------
// echo_escape_decoder
// Output stage of an echo command: separators, newline and escape decoding.
// ---------------------------------------------------------------------------
// Input stream: one word per argument byte or end marker; s_tuser holds the
// opcode (byte, end of argument, end of command), s_tdata the byte.
// Output stream: one word per output character; m_tlast marks the last word
// caused by one input word, m_tuser[1] the last word of a command, and a word
// with m_tuser[0] low is a bare end marker with m_tdata zero.
// Config channel: cfg_index 0 enables escapes, 1 suppresses the newline;
// always ready. The user must write it only while the block is idle; the
// block does not enforce this. Throughput: one input word per cycle while
// each yields one output word; an input that yields two words holds the
// output port for both, and the entry queue of QUEUE_DEPTH entries between
// decode and output absorbs that. When the receiver stalls the output word
// holds, the queue fills and s_tready drops. Reset clears the config
// registers, decode state and queue.
// ---------------------------------------------------------------------------
module echo_escape_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // in_byte
  input  logic [1:0] s_tuser,   // opcode
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte
  output logic [1:0] m_tuser,   // byte_valid, end_of_output
  output logic       m_tlast,   // last_of_run
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic       cfg_data
);

  eed_pkg::entry_t wr_entry;
  eed_pkg::entry_t rd_entry;
  logic push;
  logic pop;
  logic q_empty;
  logic q_full;
  logic accept;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_full;
  assign accept    = s_tvalid && s_tready;

  eed_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .opcode    (s_tuser),
    .in_byte   (s_tdata),
    .push      (push),
    .entry     (wr_entry)
  );

  eed_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .rd_entry (rd_entry),
    .empty    (q_empty),
    .full     (q_full)
  );

  eed_back u_back (
    .clk      (clk),
    .rst      (rst),
    .entry    (rd_entry),
    .q_empty  (q_empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

>>> hw/rtl/eed_front.sv
// ---------------------------------------------------------------------------
// eed_front
// Config registers and escape decode state; turns each input word that emits
// output into a queue entry of one or two output words.
// ---------------------------------------------------------------------------
module eed_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  input  logic            cfg_index,
  input  logic            cfg_data,
  input  logic            accept,
  input  logic [1:0]      opcode,
  input  logic [7:0]      in_byte,
  output logic            push,
  output eed_pkg::entry_t entry
);

  logic interp;
  logic suppress;
  eed_pkg::mode_t mode;
  eed_pkg::mode_t mode_next;
  logic [8:0] esc_val;
  logic [8:0] esc_val_next;
  logic [1:0] dig_cnt;
  logic [1:0] dig_cnt_next;
  logic       emit;

  logic       oct_ok;
  logic       hex_ok;
  logic [3:0] hex_val;
  logic       bs_plain;
  logic [1:0] cnt_inc;
  logic [8:0] val_oct;
  logic [8:0] val_hex;

  always_ff @(posedge clk) begin
    if (rst) begin
      interp   <= 1'b0;
      suppress <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == eed_pkg::REG_INTERP) interp <= cfg_data;
      if (cfg_index == eed_pkg::REG_SUPPRESS) suppress <= cfg_data;
    end
  end

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_byte >= "0" && in_byte <= "9") begin
      hex_val = 4'(in_byte - "0");
    end else if (in_byte >= "a" && in_byte <= "f") begin
      hex_val = 4'(in_byte - "a" + 8'd10);
    end else if (in_byte >= "A" && in_byte <= "F") begin
      hex_val = 4'(in_byte - "A" + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign oct_ok   = (in_byte >= "0") && (in_byte <= "7");
  assign bs_plain = interp && (in_byte == eed_pkg::CH_BSLASH);
  assign cnt_inc  = dig_cnt + 2'd1;
  assign val_oct  = {esc_val[5:0], in_byte[2:0]};
  assign val_hex  = {esc_val[4:0], hex_val};

  // next decode mode
  always_comb begin
    mode_next = mode;
    unique case (eed_pkg::op_t'(opcode))
      eed_pkg::OP_BYTE: begin
        unique case (mode)
          eed_pkg::MODE_BSLASH: begin
            if (in_byte == "c") mode_next = eed_pkg::MODE_STOPPED;
            else if (in_byte == "x") mode_next = eed_pkg::MODE_HEX;
            else if (oct_ok) mode_next = eed_pkg::MODE_OCTAL;
            else mode_next = eed_pkg::MODE_NORMAL;
          end
          eed_pkg::MODE_OCTAL: begin
            if (oct_ok) begin
              if (cnt_inc >= eed_pkg::OCT_DIGITS) mode_next = eed_pkg::MODE_NORMAL;
            end else begin
              mode_next = bs_plain ? eed_pkg::MODE_BSLASH : eed_pkg::MODE_NORMAL;
            end
          end
          eed_pkg::MODE_HEX: begin
            if (hex_ok) begin
              if (cnt_inc >= eed_pkg::HEX_DIGITS) mode_next = eed_pkg::MODE_NORMAL;
            end else begin
              mode_next = bs_plain ? eed_pkg::MODE_BSLASH : eed_pkg::MODE_NORMAL;
            end
          end
          eed_pkg::MODE_STOPPED: mode_next = eed_pkg::MODE_STOPPED;
          default: mode_next = bs_plain ? eed_pkg::MODE_BSLASH : eed_pkg::MODE_NORMAL;
        endcase
      end
      eed_pkg::OP_SEP: begin
        if (mode != eed_pkg::MODE_STOPPED) mode_next = eed_pkg::MODE_NORMAL;
      end
      eed_pkg::OP_END: mode_next = eed_pkg::MODE_NORMAL;
      default: mode_next = mode;
    endcase
  end

  // output words and digit accumulator
  always_comb begin
    emit         = 1'b0;
    entry        = '0;
    entry.v0     = 1'b1;
    esc_val_next = esc_val;
    dig_cnt_next = dig_cnt;
    unique case (eed_pkg::op_t'(opcode))
      eed_pkg::OP_BYTE: begin
        unique case (mode)
          eed_pkg::MODE_BSLASH: begin
            emit = 1'b1;
            case (in_byte)
              "a":  entry.b0 = 8'h07;
              "b":  entry.b0 = 8'h08;
              "e":  entry.b0 = eed_pkg::CH_ESC;
              "f":  entry.b0 = 8'h0C;
              "n":  entry.b0 = 8'h0A;
              "r":  entry.b0 = 8'h0D;
              "t":  entry.b0 = 8'h09;
              "v":  entry.b0 = 8'h0B;
              eed_pkg::CH_BSLASH: entry.b0 = eed_pkg::CH_BSLASH;
              "c":  emit = 1'b0;
              "x": begin
                emit         = 1'b0;
                esc_val_next = '0;
                dig_cnt_next = '0;
              end
              default: begin
                if (oct_ok) begin
                  emit         = 1'b0;
                  esc_val_next = {6'd0, in_byte[2:0]};
                  dig_cnt_next = 2'd1;
                end else begin
                  entry.two = 1'b1;
                  entry.b0  = eed_pkg::CH_BSLASH;
                  entry.b1  = in_byte;
                end
              end
            endcase
          end
          eed_pkg::MODE_OCTAL, eed_pkg::MODE_HEX: begin
            if ((mode == eed_pkg::MODE_OCTAL) ? oct_ok : hex_ok) begin
              esc_val_next = (mode == eed_pkg::MODE_OCTAL) ? val_oct : val_hex;
              dig_cnt_next = cnt_inc;
              if (cnt_inc >= ((mode == eed_pkg::MODE_OCTAL) ? eed_pkg::OCT_DIGITS
                                                             : eed_pkg::HEX_DIGITS)) begin
                emit         = 1'b1;
                entry.b0     = esc_val_next[7:0];
                esc_val_next = '0;
                dig_cnt_next = '0;
              end
            end else begin
              emit         = 1'b1;
              entry.b0     = esc_val[7:0];
              entry.two    = !bs_plain;
              entry.b1     = in_byte;
              esc_val_next = '0;
              dig_cnt_next = '0;
            end
          end
          eed_pkg::MODE_STOPPED: emit = 1'b0;
          default: begin
            emit     = !bs_plain;
            entry.b0 = in_byte;
          end
        endcase
      end
      eed_pkg::OP_SEP: begin
        if (mode != eed_pkg::MODE_STOPPED) begin
          emit         = 1'b1;
          esc_val_next = '0;
          dig_cnt_next = '0;
          entry.b1     = eed_pkg::CH_SPACE;
          if (mode == eed_pkg::MODE_OCTAL || mode == eed_pkg::MODE_HEX) begin
            entry.two = 1'b1;
            entry.b0  = esc_val[7:0];
          end else if (mode == eed_pkg::MODE_BSLASH) begin
            entry.two = 1'b1;
            entry.b0  = eed_pkg::CH_BSLASH;
          end else begin
            entry.b0  = eed_pkg::CH_SPACE;
          end
        end
      end
      eed_pkg::OP_END: begin
        emit         = 1'b1;
        entry.eoc    = 1'b1;
        esc_val_next = '0;
        dig_cnt_next = '0;
        entry.b1     = eed_pkg::CH_NL;
        if (mode == eed_pkg::MODE_OCTAL || mode == eed_pkg::MODE_HEX) begin
          entry.b0  = esc_val[7:0];
          entry.two = !suppress;
        end else if (mode == eed_pkg::MODE_BSLASH) begin
          entry.b0  = eed_pkg::CH_BSLASH;
          entry.two = !suppress;
        end else if (mode != eed_pkg::MODE_STOPPED && !suppress) begin
          entry.b0  = eed_pkg::CH_NL;
        end else begin
          // bare end marker
          entry.v0  = 1'b0;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= eed_pkg::MODE_NORMAL;
      esc_val <= '0;
      dig_cnt <= '0;
    end else if (accept) begin
      mode    <= mode_next;
      esc_val <= esc_val_next;
      dig_cnt <= dig_cnt_next;
    end
  end

endmodule

>>> hw/rtl/eed_queue.sv
// ---------------------------------------------------------------------------
// eed_queue
// Small first-in first-out queue of decoded entries between front and back.
// ---------------------------------------------------------------------------
module eed_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  eed_pkg::entry_t wr_entry,
  input  logic            pop,
  output eed_pkg::entry_t rd_entry,
  output logic            empty,
  output logic            full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  eed_pkg::entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty    = (count == '0);
  assign full     = (count == CNT_FULL);
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop) count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

endmodule

>>> hw/rtl/eed_back.sv
// ---------------------------------------------------------------------------
// eed_back
// Unpacks queue entries into output words through a registered output stage.
// ---------------------------------------------------------------------------
module eed_back (
  input  logic            clk,
  input  logic            rst,
  input  eed_pkg::entry_t entry,
  input  logic            q_empty,
  output logic            pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata,
  output logic [1:0]      m_tuser,
  output logic            m_tlast
);

  logic phase;
  logic load;
  logic take;

  assign load = !m_tvalid || m_tready;
  assign take = load && !q_empty;
  assign pop  = take && (phase || !entry.two);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      phase    <= 1'b0;
    end else begin
      if (load) m_tvalid <= !q_empty;
      if (take) phase <= !phase && entry.two;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (phase) begin
        m_tdata <= entry.b1;
        m_tuser <= {entry.eoc, 1'b1};
        m_tlast <= 1'b1;
      end else begin
        m_tdata <= entry.b0;
        m_tuser <= {entry.eoc && !entry.two, entry.v0};
        m_tlast <= !entry.two;
      end
    end
  end

endmodule

>>> hw/rtl/eed_checker.sv
// ---------------------------------------------------------------------------
// eed_checker
// Port-level checks on the output stream of the echo escape decoder.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module eed_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [1:0] m_tuser,
  input logic       m_tlast
);

  `EED_ASSERT(a_eoc_is_last, clk, rst, m_tvalid && m_tuser[1] |-> m_tlast)
  `EED_ASSERT(a_bare_marker, clk, rst, m_tvalid && !m_tuser[0] |-> m_tuser[1] && m_tlast && m_tdata == 8'd0)
  `EED_ASSERT(a_stall_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
  `EED_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !m_tvalid)

endmodule

bind echo_escape_decoder eed_checker u_eed_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
